// ----- src/swm_pkg.sv -----
// Shared types and constants for the sliding window maximum block.
`default_nettype none
package swm_pkg;

  localparam int WS_WIDTH   = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [0:0]          REG_WINDOW_SIZE = 1'b0;
  localparam logic [WS_WIDTH-1:0] WS_RESET        = 7'd1;

  typedef struct packed {
    logic step;
    logic shift;
    logic head;
    logic clear;
  } swm_ctrl_t;

endpackage
`default_nettype wire

// ----- src/swm_if.sv -----
// Valid/ready stream interfaces for sample items and result items.
`default_nettype none
interface swm_in_if #(parameter int DW = 32);
  logic          valid;
  logic          ready;
  logic [DW-1:0] sample;
  logic          starts_sequence;

  modport source (output valid, output sample, output starts_sequence, input ready);
  modport sink (input valid, input sample, input starts_sequence, output ready);
endinterface

interface swm_out_if #(parameter int DW = 32);
  logic          valid;
  logic          ready;
  logic [DW-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink (input valid, input window_max, output ready);
endinterface
`default_nettype wire

// ----- src/swm_cell.sv -----
// One candidate slot of the monotone queue; shifts toward the head with its neighbor.
`default_nettype none
module swm_cell #(
  parameter int SW        = 32,
  parameter int AW        = 6,
  parameter bit HEAD_SLOT = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::swm_ctrl_t  ctrl,
  input  logic [SW-1:0]       sample,
  input  logic [AW-1:0]       age_lim,
  input  logic                left_surv,
  input  logic                right_valid,
  input  logic                right_surv,
  input  logic [SW-1:0]       right_value,
  input  logic [AW-1:0]       right_age,
  output logic                valid,
  output logic                surv,
  output logic [SW-1:0]       value,
  output logic [AW-1:0]       age,
  output logic [SW-1:0]       value_nxt
);
  import swm_pkg::*;

  logic          valid_r, valid_nxt;
  logic [SW-1:0] value_r, val_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic          prev_surv, src_surv, append;
  logic [SW-1:0] src_value;
  logic [AW-1:0] src_age;

  // survives this item: in window and not beaten by the new sample
  assign surv = valid_r && !ctrl.clear && (age_r < age_lim) &&
                !($signed(value_r) < $signed(sample));

  // when the head drops, the head slot has nothing ahead of it
  assign prev_surv = ctrl.head ? (surv || HEAD_SLOT) : left_surv;
  assign src_surv  = ctrl.head ? right_surv : surv;
  assign src_value = ctrl.head ? right_value : value_r;
  assign src_age   = ctrl.head ? right_age : age_r;
  assign append    = !src_surv && prev_surv;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = value_r;
    age_nxt   = age_r;
    if (ctrl.shift) begin
      valid_nxt = right_valid;
      val_nxt   = right_value;
      age_nxt   = right_age;
    end else if (ctrl.step) begin
      if (src_surv) begin
        valid_nxt = 1'b1;
        val_nxt   = src_value;
        age_nxt   = src_age + AW'(1);
      end else if (append) begin
        valid_nxt = 1'b1;
        val_nxt   = sample;
        age_nxt   = '0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= val_nxt;
    age_r   <= age_nxt;
  end

  assign valid     = valid_r;
  assign value     = value_r;
  assign age       = age_r;
  assign value_nxt = val_nxt;

endmodule
`default_nettype wire

// ----- src/sliding_window_maximum_unit.sv -----
// Top level of the streaming sliding window maximum filter.
// Usage:
//   in_ch carries one signed sample per item plus starts_sequence, which
//   empties the window so the item begins a new sequence. out_ch carries
//   window_max, the maximum of the last window_size samples, once
//   window_size samples of the current sequence have been seen; earlier
//   items produce no result. window_size is written over the APB port at
//   byte address 0 (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW).
//   The result of an accepted item is registered into the output buffer.
//   Throughput: one item per cycle while in_ch.ready is high. The
//   candidates sit in a chain of MAX_WINDOW cells compared in parallel
//   against the new sample. After window_size is lowered, in_ch.ready is
//   held low while stale candidates are shifted out of the head cell.
//   A two-entry output buffer keeps in_ch.ready high while one result
//   waits; a second waiting result holds in_ch.ready low.
//   Reset (rst_n, synchronous) empties the queue and output buffer,
//   clears the fill count and sets window_size to 1.
`default_nettype none
module sliding_window_maximum_unit #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  swm_in_if.sink                              in_ch,
  swm_out_if.source                           out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [swm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [swm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import swm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (FW > WS_WIDTH) ? FW : WS_WIDTH;

  logic [WS_WIDTH-1:0]     ws_r;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           w_raw, w_eff;
  logic [AW-1:0]           age_lim;
  logic                    cfg_wr;
  logic                    accept, prepass, emit;
  swm_ctrl_t               ctrl;

  logic                    c_valid [MAX_WINDOW+1];
  logic                    c_surv  [MAX_WINDOW+1];
  logic [SAMPLE_WIDTH-1:0] c_value [MAX_WINDOW+1];
  logic [AW-1:0]           c_age   [MAX_WINDOW+1];
  logic [SAMPLE_WIDTH-1:0] c_vnxt  [MAX_WINDOW];

  logic                    out_v_r, sk_v_r;
  logic [SAMPLE_WIDTH-1:0] out_d_r, sk_d_r;
  logic                    pop, push;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                  {{(CFG_DATA_W-WS_WIDTH){1'b0}}, ws_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else if (cfg_wr && (paddr[2] == REG_WINDOW_SIZE)) begin
      ws_r <= pwdata[WS_WIDTH-1:0];
    end
  end

  assign w_raw   = CW'(ws_r);
  assign w_eff   = (w_raw == '0) ? CW'(1) :
                   ((w_raw > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : w_raw);
  assign age_lim = AW'(w_eff - CW'(1));

  // handshake and control
  assign prepass     = c_valid[1] && (c_age[1] >= age_lim);
  assign in_ch.ready = !prepass && !sk_v_r;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    ctrl.step  = accept;
    ctrl.shift = prepass;
    ctrl.clear = in_ch.starts_sequence;
    ctrl.head  = c_valid[0] && (c_age[0] >= age_lim) && !in_ch.starts_sequence;
  end

  // candidate chain; the entry past the tail is always empty
  assign c_valid[MAX_WINDOW] = 1'b0;
  assign c_surv[MAX_WINDOW]  = 1'b0;
  assign c_value[MAX_WINDOW] = '0;
  assign c_age[MAX_WINDOW]   = '0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell #(
      .SW        (SAMPLE_WIDTH),
      .AW        (AW),
      .HEAD_SLOT (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (in_ch.sample),
      .age_lim     (age_lim),
      .left_surv   ((i == 0) ? 1'b1 : c_surv[(i == 0) ? 0 : i-1]),
      .right_valid (c_valid[i+1]),
      .right_surv  (c_surv[i+1]),
      .right_value (c_value[i+1]),
      .right_age   (c_age[i+1]),
      .valid       (c_valid[i]),
      .surv        (c_surv[i]),
      .value       (c_value[i]),
      .age         (c_age[i]),
      .value_nxt   (c_vnxt[i])
    );
  end

  // fill count
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_ch.starts_sequence) begin
        fill_nxt = FW'(1);
      end else if (fill_r < FW'(MAX_WINDOW)) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign emit = CW'(fill_nxt) >= w_eff;

  // two-entry output buffer
  assign pop  = out_v_r && out_ch.ready;
  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (pop) begin
      if (sk_v_r) begin
        sk_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      if (out_v_r) begin
        sk_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_d_r <= sk_v_r ? sk_d_r : c_vnxt[0];
    end else if (push) begin
      if (out_v_r) begin
        sk_d_r <= c_vnxt[0];
      end else begin
        out_d_r <= c_vnxt[0];
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.window_max = out_d_r;

  // checks
  a_prepass_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    prepass |-> !in_ch.ready)
    else $error("item accepted while stale candidates remain");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_new_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.starts_sequence) |=> (fill_r == FW'(1)) && c_valid[0])
    else $error("new sequence not started cleanly");

  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> c_valid[0])
    else $error("head cell empty after an item");

endmodule
`default_nettype wire

// ----- sim/sliding_window_maximum_unit_test.sv -----
// Self-checking testbench for the sliding window maximum unit: directed rows, then random phases.
`timescale 1ns / 100ps
module sliding_window_maximum_unit_test;
  import swm_pkg::*;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ITEM_TARGET  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int REG_SPARE    = 1;

  typedef enum logic [0:0] {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        sos;
    logic        typed;
    logic [31:0] typed_max;
  } dir_row_t;

  localparam logic [1:0] RW = 2'(REG_WINDOW_SIZE);
  localparam logic [1:0] RS = 2'(REG_SPARE);

  localparam int N_ROWS = 28;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_ITEM,  RW, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_ITEM,  RW, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ITEM,  RW, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{ROW_ITEM,  RW, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{ROW_WRITE, RW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005},
    '{ROW_ITEM,  RW, 32'hFFFF_FFF9, 1'b0, 1'b1, 32'hFFFF_FFF9},
    '{ROW_WRITE, RW, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_000A, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_000A, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_000A, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0008, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, RS, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0004, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, RW, 32'hFFFF_FF7F, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, RW, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM,  RW, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  swm_in_if  #(.DW(SAMPLE_WIDTH)) in_ch ();
  swm_out_if #(.DW(SAMPLE_WIDTH)) out_ch ();

  sliding_window_maximum_unit #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  logic [WS_WIDTH-1:0]   win_len_reg;
  logic signed [31:0]    peak_vals[$];
  int                    peak_ages[$];
  int                    seq_count;

  logic [31:0] pending_max[$];
  logic [31:0] seen_max;
  int          mismatch_count;
  int          items_sent;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_request;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic bit window_max_step(input logic signed [31:0] s, input logic sos,
                                         output logic [31:0] mx);
    int w;
    w = int'(win_len_reg);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    mx = '0;
    if (sos) begin
      peak_vals.delete();
      peak_ages.delete();
      seq_count = 0;
    end
    foreach (peak_ages[i]) peak_ages[i] = peak_ages[i] + 1;
    while (peak_ages.size() > 0 && peak_ages[0] >= w) begin
      peak_vals.delete(0);
      peak_ages.delete(0);
    end
    // equal older samples stay, so the queue is non-increasing
    while (peak_vals.size() > 0 && peak_vals[peak_vals.size()-1] < s) begin
      peak_vals.delete(peak_vals.size() - 1);
      peak_ages.delete(peak_ages.size() - 1);
    end
    if (peak_vals.size() < MAX_WINDOW) begin
      peak_vals = {peak_vals, s};
      peak_ages = {peak_ages, 0};
    end
    if (seq_count < MAX_WINDOW) seq_count++;
    if (seq_count >= w) begin
      mx = peak_vals[0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input bit has_want, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (has_want)
        $display("%0t: window_max expected %0d got %0d", $realtime, $signed(want),
                 $signed(got));
      else
        $display("%0t: window_max %0d with no item expected", $realtime, $signed(got));
    end
  endtask

  task automatic push_item(input logic [31:0] s, input logic sos, input logic typed,
                           input logic [31:0] typed_max);
    int          gap;
    logic [31:0] mx;
    bit          has;
    gap = src_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample          <= s;
    in_ch.starts_sequence <= sos;
    do @(posedge clk); while (!in_ch.ready);
    has = window_max_step(s, sos, mx);
    if (typed) pending_max = {pending_max, typed_max};
    else if (has) pending_max = {pending_max, mx};
    items_sent++;
  endtask

  // wait until every result is in, plus a flush margin for stale head cells
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (MAX_WINDOW + 8) @(posedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx << 2);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(REG_WINDOW_SIZE)) win_len_reg = data[WS_WIDTH-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample(input int style, input int k,
                                              input logic [31:0] base);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 6)) - 3);
      2: return base + 32'(k * 3);
      3: return base - 32'(k);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h8000_0001;
          default: return 32'h7FFF_FFFE;
        endcase
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_max.size() == 0) begin
        flag_mismatch(1'b0, '0, out_ch.window_max);
      end else begin
        seen_max = pending_max[0];
        pending_max.delete(0);
        if (out_ch.window_max !== seen_max) flag_mismatch(1'b1, seen_max, out_ch.window_max);
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int          phase;
    int          eff_w;
    int          phase_len;
    int          seq_len;
    int          style;
    int          wsel;
    logic [31:0] base;
    logic        sos;

    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.sample          = '0;
    in_ch.starts_sequence = 1'b0;
    win_len_reg           = WS_RESET;
    seq_count             = 0;
    mismatch_count        = 0;
    items_sent            = 0;
    src_gaps              = 1'b1;
    sink_gaps             = 1'b1;
    hold_request          = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_WRITE) begin
        settle();
        apb_write(int'(DIR_ROWS[r].reg_idx), DIR_ROWS[r].value);
      end else begin
        push_item(DIR_ROWS[r].value, DIR_ROWS[r].sos, DIR_ROWS[r].typed,
                  DIR_ROWS[r].typed_max);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       wsel = 1;
        1:       wsel = MAX_WINDOW;
        2:       wsel = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_WINDOW + 1, 127);
        3, 4:    wsel = $urandom_range(1, MAX_WINDOW);
        default: wsel = $urandom_range(1, 12);
      endcase
      if (phase == 2) wsel = 2;
      settle();
      apb_write(int'(REG_WINDOW_SIZE), ($urandom & 32'hFFFF_FF80) | 32'(wsel));
      if ($urandom_range(0, 5) == 0) apb_write(REG_SPARE, $urandom);
      eff_w = (wsel == 0) ? 1 : (wsel > MAX_WINDOW ? MAX_WINDOW : wsel);

      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        src_gaps     = 1'b0;
        hold_request = 1'b1;
      end

      phase_len = $urandom_range(60, 160) + 2 * eff_w;
      while (phase_len > 0) begin
        seq_len = $urandom_range(1, 3 * eff_w + 4);
        style   = $urandom_range(0, 4);
        base    = $urandom;
        for (int k = 0; k < seq_len && phase_len > 0; k++) begin
          if (k == 0) sos = ($urandom_range(0, 5) != 0);
          else sos = ($urandom_range(0, 99) == 0);
          push_item(pick_sample(style, k, base), sos, 1'b0, '0);
          phase_len--;
        end
      end
      phase++;
    end

    settle();
    mismatch_count += pending_max.size();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
